// ----- hdl/los_pkg.sv -----
// los_pkg: types, constants and reset values shared by the lidar obstacle steering block.
// No dependencies.
`timescale 1ns / 1ps

package los_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int DIST_W  = 14;
    localparam int ANGLE_W = 9;
    localparam int TOTAL_W = 16;
    localparam int HITS_W  = 7;
    localparam int FWD_W   = 13;
    localparam int HALF_W  = 15;
    localparam int WHEEL_W = 16;
    localparam int CODE_W  = 2;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [ANGLE_W-1:0] ANGLE_SPLIT = 9'd50;
    localparam logic [ANGLE_W:0]   FULL_TURN   = 10'd360;
    localparam logic [FWD_W-1:0]   FWD_CEILING = 13'd5117;

    localparam logic [CODE_W-1:0] POS_CLEAR = 2'd0;
    localparam logic [CODE_W-1:0] POS_RIGHT = 2'd1;
    localparam logic [CODE_W-1:0] POS_LEFT  = 2'd2;

    localparam logic [2:0] REG_HIT_RANGE    = 3'd0;
    localparam logic [2:0] REG_FORWARD_MAX  = 3'd1;
    localparam logic [2:0] REG_FORWARD_STEP = 3'd2;
    localparam logic [2:0] REG_TURN_RATE    = 3'd3;
    localparam logic [2:0] REG_WHEEL_TRACK  = 3'd4;
    localparam logic [2:0] REG_SPEED_LIMIT  = 3'd5;

    localparam logic [13:0] HIT_RANGE_RST    = 14'd255;
    localparam logic [11:0] FORWARD_MAX_RST  = 12'd983;
    localparam logic [9:0]  FORWARD_STEP_RST = 10'd41;
    localparam logic [13:0] TURN_RATE_RST    = 14'd3899;
    localparam logic [12:0] WHEEL_TRACK_RST  = 13'd819;
    localparam logic [14:0] SPEED_LIMIT_RST  = 15'd14336;

    typedef struct packed {
        logic [13:0] hit_range;
        logic [11:0] forward_max;
        logic [9:0]  forward_step;
        logic [13:0] turn_rate;
        logic [12:0] wheel_track;
        logic [14:0] speed_limit;
    } cfg_t;

    // one finished scan as handed from front to back
    typedef struct packed {
        logic hit;
        logic turn_left;
    } scan_sum_t;

endpackage

// ----- hdl/los_regs.sv -----
// los_regs: APB-style configuration register file.
// Depends on los_pkg.
`timescale 1ns / 1ps

module los_regs
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [los_pkg::ADDR_W-1:0] paddr,
    input  logic [los_pkg::DATA_W-1:0] pwdata,
    output logic [los_pkg::DATA_W-1:0] prdata,
    output los_pkg::cfg_t             cfg
);
    import los_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index = paddr[ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hit_range    <= HIT_RANGE_RST;
            cfg_reg.forward_max  <= FORWARD_MAX_RST;
            cfg_reg.forward_step <= FORWARD_STEP_RST;
            cfg_reg.turn_rate    <= TURN_RATE_RST;
            cfg_reg.wheel_track  <= WHEEL_TRACK_RST;
            cfg_reg.speed_limit  <= SPEED_LIMIT_RST;
        end
        else if (wr_en)
        begin
            case (index)
                REG_HIT_RANGE:    cfg_reg.hit_range    <= pwdata[13:0];
                REG_FORWARD_MAX:  cfg_reg.forward_max  <= pwdata[11:0];
                REG_FORWARD_STEP: cfg_reg.forward_step <= pwdata[9:0];
                REG_TURN_RATE:    cfg_reg.turn_rate    <= pwdata[13:0];
                REG_WHEEL_TRACK:  cfg_reg.wheel_track  <= pwdata[12:0];
                REG_SPEED_LIMIT:  cfg_reg.speed_limit  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_HIT_RANGE:    prdata = {18'd0, cfg_reg.hit_range};
            REG_FORWARD_MAX:  prdata = {20'd0, cfg_reg.forward_max};
            REG_FORWARD_STEP: prdata = {22'd0, cfg_reg.forward_step};
            REG_TURN_RATE:    prdata = {18'd0, cfg_reg.turn_rate};
            REG_WHEEL_TRACK:  prdata = {19'd0, cfg_reg.wheel_track};
            REG_SPEED_LIMIT:  prdata = {17'd0, cfg_reg.speed_limit};
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- hdl/los_front.sv -----
// los_front: accepts lidar points, classifies hits and accumulates angle sum and hit count.
// Emits one scan summary per last-of-scan point. Depends on los_pkg.
`timescale 1ns / 1ps

module los_front
#(
    parameter int MAX_POINTS = los_pkg::MAX_POINTS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  los_pkg::cfg_t               cfg,
    input  logic                        take,
    input  logic [los_pkg::DIST_W-1:0]  point_distance,
    input  logic [los_pkg::ANGLE_W-1:0] point_angle,
    input  logic                        scan_last,
    output logic                        sum_push,
    output los_pkg::scan_sum_t          sum_word
);
    import los_pkg::*;

    localparam int IW = $clog2(MAX_POINTS + 1);

    logic signed [TOTAL_W-1:0] total_reg, total_next;
    logic [HITS_W-1:0]         hits_reg, hits_next;
    logic [IW-1:0]             index_reg, index_next;

    logic                      counted;
    logic                      is_hit;
    logic signed [ANGLE_W:0]   addend;
    logic signed [TOTAL_W:0]   sum_wide;

    always_comb
    begin
        counted = index_reg < IW'(MAX_POINTS);
        is_hit  = counted && (point_distance != '0) &&
                  (point_distance < cfg.hit_range);
        if (point_angle < ANGLE_SPLIT)
            addend = $signed({1'b0, point_angle});
        else
            addend = $signed({1'b0, point_angle} - FULL_TURN);
        sum_wide = {total_reg[TOTAL_W-1], total_reg} +
                   {{(TOTAL_W-ANGLE_W){addend[ANGLE_W]}}, addend};

        total_next = total_reg;
        hits_next  = hits_reg;
        index_next = index_reg;
        if (counted)
            index_next = index_reg + 1'b1;
        if (is_hit)
        begin
            if (sum_wide > $signed({2'b00, {(TOTAL_W-1){1'b1}}}))
                total_next = {1'b0, {(TOTAL_W-1){1'b1}}};
            else if (sum_wide < $signed({2'b11, {(TOTAL_W-1){1'b0}}}))
                total_next = {1'b1, {(TOTAL_W-1){1'b0}}};
            else
                total_next = sum_wide[TOTAL_W-1:0];
            if (hits_reg != {HITS_W{1'b1}})
                hits_next = hits_reg + 1'b1;
        end

        sum_push           = take && scan_last;
        sum_word.hit       = hits_next != '0;
        sum_word.turn_left = total_next > 0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            hits_reg  <= '0;
            index_reg <= '0;
        end
        else if (take)
        begin
            if (scan_last)
            begin
                total_reg <= '0;
                hits_reg  <= '0;
                index_reg <= '0;
            end
            else
            begin
                total_reg <= total_next;
                hits_reg  <= hits_next;
                index_reg <= index_next;
            end
        end
    end

endmodule

// ----- hdl/los_queue.sv -----
// los_queue: short first-in first-out queue of scan summaries between front and back.
// Depends on los_pkg.
`timescale 1ns / 1ps

module los_queue
#(
    parameter int DEPTH = los_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  los_pkg::scan_sum_t wdata,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output los_pkg::scan_sum_t rdata
);
    import los_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    scan_sum_t     slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full    = count_reg == CW'(DEPTH);
    assign valid   = count_reg != '0;
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- hdl/los_back.sv -----
// los_back: forward speed ramp, differential-drive kinematics, clamping and result register.
// Depends on los_pkg.
`timescale 1ns / 1ps

module los_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  los_pkg::cfg_t                cfg,
    input  logic                         sum_valid,
    input  los_pkg::scan_sum_t           sum_word,
    output logic                         sum_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic [los_pkg::CODE_W-1:0]   position_code,
    output logic signed [los_pkg::WHEEL_W-1:0] left_target,
    output logic signed [los_pkg::WHEEL_W-1:0] right_target,
    output logic [los_pkg::FWD_W-1:0]    forward_now
);
    import los_pkg::*;

    logic [FWD_W-1:0]          fwd_reg, fwd_next;
    logic [HALF_W-1:0]         half_reg;
    logic [27:0]               prod;
    logic                      out_valid_reg;
    logic [CODE_W-1:0]         code_reg, code_next;
    logic signed [WHEEL_W-1:0] left_reg, left_next;
    logic signed [WHEEL_W-1:0] right_reg, right_next;
    logic [FWD_W-1:0]          fwd_out_reg;

    logic                      take;
    logic signed [16:0]        fwd_s, half_s, lim_s, left_raw, right_raw;

    function automatic logic signed [WHEEL_W-1:0] clamp(
        input logic signed [16:0] v,
        input logic signed [16:0] lim
    );
        logic signed [16:0] r;
        if (v < -lim)
            r = -lim;
        else if (v > lim)
            r = lim;
        else
            r = v;
        return r[WHEEL_W-1:0];
    endfunction

    assign prod  = 28'(cfg.turn_rate) * 28'(cfg.wheel_track) + 28'd4096;
    assign take  = sum_valid && (!out_valid_reg || pop);
    assign sum_pop = take;
    assign empty = !out_valid_reg;

    always_comb
    begin
        if (!sum_word.hit)
        begin
            fwd_next  = (fwd_reg < {1'b0, cfg.forward_max}) ?
                        fwd_reg + FWD_W'(cfg.forward_step) : fwd_reg;
            code_next = POS_CLEAR;
        end
        else
        begin
            fwd_next  = '0;
            code_next = sum_word.turn_left ? POS_RIGHT : POS_LEFT;
        end
        fwd_s  = $signed({4'd0, fwd_next});
        half_s = $signed({2'd0, half_reg});
        lim_s  = $signed({2'd0, cfg.speed_limit});
        case (code_next)
            POS_RIGHT:
            begin
                left_raw  = fwd_s - half_s;
                right_raw = fwd_s + half_s;
            end
            POS_LEFT:
            begin
                left_raw  = fwd_s + half_s;
                right_raw = fwd_s - half_s;
            end
            default:
            begin
                left_raw  = fwd_s;
                right_raw = fwd_s;
            end
        endcase
        left_next  = clamp(left_raw, lim_s);
        right_next = clamp(right_raw, lim_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg       <= '0;
            half_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            half_reg <= prod[27:13];
            if (take)
            begin
                fwd_reg       <= fwd_next;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            code_reg    <= code_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            fwd_out_reg <= fwd_next;
        end
    end

    assign position_code = code_reg;
    assign left_target   = left_reg;
    assign right_target  = right_reg;
    assign forward_now   = fwd_out_reg;

    a_fwd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg <= FWD_CEILING)
        else $error("forward speed beyond ramp ceiling");

    a_clear_straight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (code_reg == POS_CLEAR) |-> left_reg == right_reg)
        else $error("clear scan with unequal wheel targets");

    a_avoid_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (code_reg != POS_CLEAR) |-> fwd_out_reg == '0)
        else $error("avoiding scan with nonzero forward speed");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(left_reg))
        else $error("waiting word lost or changed");

endmodule

// ----- hdl/lidar_obstacle_steering_top.sv -----
// Lidar obstacle steering top level: register file, front, summary queue and back.
// One point per cycle accepted unless full; a last-of-scan word is registered in the summary
// queue, then the back result register. Results sustain one per cycle while pop keeps up.
// Reset (rst_n low, asynchronous) clears sums, counts, speed and queues; registers to defaults.
// Depends on los_pkg, los_regs, los_front, los_queue, los_back.
`timescale 1ns / 1ps

module lidar_obstacle_steering_top
#(
    parameter int MAX_POINTS  = los_pkg::MAX_POINTS_DEF,
    parameter int QUEUE_DEPTH = los_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [los_pkg::ADDR_W-1:0]    paddr,
    input  logic [los_pkg::DATA_W-1:0]    pwdata,
    output logic [los_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  logic [los_pkg::DIST_W-1:0]    point_distance,
    input  logic [los_pkg::ANGLE_W-1:0]   point_angle,
    input  logic                          scan_last,
    output logic                          empty,
    input  logic                          pop,
    output logic [los_pkg::CODE_W-1:0]    position_code,
    output logic signed [los_pkg::WHEEL_W-1:0] left_target,
    output logic signed [los_pkg::WHEEL_W-1:0] right_target,
    output logic [los_pkg::FWD_W-1:0]     forward_now
);
    import los_pkg::*;

    cfg_t      cfg;
    logic      take;
    logic      sum_push, sum_pop, sum_valid;
    scan_sum_t sum_in, sum_out;

    assign pready = 1'b1;
    assign take   = push && !full;

    los_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    los_front #(.MAX_POINTS(MAX_POINTS)) u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .take           (take),
        .point_distance (point_distance),
        .point_angle    (point_angle),
        .scan_last      (scan_last),
        .sum_push       (sum_push),
        .sum_word       (sum_in)
    );

    los_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (sum_push),
        .wdata (sum_in),
        .full  (full),
        .pop   (sum_pop),
        .valid (sum_valid),
        .rdata (sum_out)
    );

    los_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .sum_valid     (sum_valid),
        .sum_word      (sum_out),
        .sum_pop       (sum_pop),
        .empty         (empty),
        .pop           (pop),
        .position_code (position_code),
        .left_target   (left_target),
        .right_target  (right_target),
        .forward_now   (forward_now)
    );

endmodule
